>>> rtl/multiword_schoolbook_multiplier_top_defines.svh
// assertion macros for the rtl top, sampled on clk and disabled while rst_n is low
`ifndef MULTIWORD_SCHOOLBOOK_MULTIPLIER_TOP_DEFINES_SVH
`define MULTIWORD_SCHOOLBOOK_MULTIPLIER_TOP_DEFINES_SVH

// same-cycle implication
`define MWSM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define MWSM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/mwsm_pkg.sv
`default_nettype none

package mwsm_pkg;

  localparam int OPERAND_WORDS = 16;
  localparam int WORD_W        = 32;

  // control that travels with one multiply-accumulate step
  typedef struct packed {
    logic valid;
    logic first;       // first step of a row, carry in is zero
    logic carry_step;  // extra step that stores the row carry
    logic zero_acc;    // ignore the product store read data
  } mac_ctl_t;

endpackage

`default_nettype wire

>>> rtl/multiword_schoolbook_multiplier_top.sv
// multi-word unsigned multiplier, 32-bit words, least significant word first
// input: while busy is low, a cycle with start high takes one word pair
//   (in_a_word, in_b_word); in_last_pair closes the operands at N words,
//   and the pair that fills the operand store closes them at OPERAND_WORDS
// after the closing pair busy stays high through the multiply-accumulate steps,
//   each row N products and a carry step (one step per cycle on the single multiplier
//   and product memory port), a wait between rows when N < 3, a drain, then the emit
// output: the 2N product words come one per cycle, least significant first,
//   each for one cycle with out_strobe high; out_last_result marks the top word
// busy drops in the cycle of the last word
// the receiver has no stall; results must be taken as they come
// reset (rst_n low, synchronous) returns to loading with no pairs held;
//   the operand and product memories are not cleared and need not be
`default_nettype none

`include "multiword_schoolbook_multiplier_top_defines.svh"

module multiword_schoolbook_multiplier_top #(
  parameter int OPERAND_WORDS = mwsm_pkg::OPERAND_WORDS
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [mwsm_pkg::WORD_W-1:0] in_a_word,
  input  wire logic [mwsm_pkg::WORD_W-1:0] in_b_word,
  input  wire logic                        in_last_pair,
  output logic                             out_strobe,
  output logic      [mwsm_pkg::WORD_W-1:0] out_product_word,
  output logic                             out_last_result
);

  localparam int AW = (OPERAND_WORDS > 1) ? $clog2(OPERAND_WORDS) : 1;
  localparam int PW = $clog2(2 * OPERAND_WORDS);

  logic                        op_wr_en;
  logic [AW-1:0]               op_wr_addr;
  logic [AW-1:0]               a_rd_addr, b_rd_addr;
  logic [PW-1:0]               p_rd_addr;
  mwsm_pkg::mac_ctl_t          issue;
  logic [PW-1:0]               issue_waddr;
  logic [mwsm_pkg::WORD_W-1:0] a_q, b_q, p_q;
  logic                        p_wr_en;
  logic [PW-1:0]               p_wr_addr;
  logic [mwsm_pkg::WORD_W-1:0] p_wr_data;

  mwsm_seq #(.OPERAND_WORDS(OPERAND_WORDS)) u_seq (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_start        (start),
    .in_last_pair    (in_last_pair),
    .busy            (busy),
    .op_wr_en        (op_wr_en),
    .op_wr_addr      (op_wr_addr),
    .a_rd_addr       (a_rd_addr),
    .b_rd_addr       (b_rd_addr),
    .p_rd_addr       (p_rd_addr),
    .issue           (issue),
    .issue_waddr     (issue_waddr),
    .out_strobe      (out_strobe),
    .out_last_result (out_last_result)
  );

  mwsm_opmem #(.OPERAND_WORDS(OPERAND_WORDS)) u_opmem (
    .clk       (clk),
    .wr_en     (op_wr_en),
    .wr_addr   (op_wr_addr),
    .wr_a      (in_a_word),
    .wr_b      (in_b_word),
    .rd_a_addr (a_rd_addr),
    .rd_b_addr (b_rd_addr),
    .rd_a_q    (a_q),
    .rd_b_q    (b_q)
  );

  mwsm_mac #(.OPERAND_WORDS(OPERAND_WORDS)) u_mac (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl_in   (issue),
    .waddr_in (issue_waddr),
    .a_q      (a_q),
    .b_q      (b_q),
    .p_q      (p_q),
    .wr_en    (p_wr_en),
    .wr_addr  (p_wr_addr),
    .wr_data  (p_wr_data)
  );

  mwsm_prodmem #(.OPERAND_WORDS(OPERAND_WORDS)) u_prodmem (
    .clk     (clk),
    .wr_en   (p_wr_en),
    .wr_addr (p_wr_addr),
    .wr_data (p_wr_data),
    .rd_addr (p_rd_addr),
    .rd_q    (p_q)
  );

  assign out_product_word = p_q;

  `MWSM_ASSERT_IMP(a_no_emit_during_write, p_wr_en, !out_strobe, "product write during emit")
  `MWSM_ASSERT_IMP(a_write_only_busy, p_wr_en, busy, "product write while idle")
  `MWSM_ASSERT_IMP(a_last_ends_busy, out_strobe && out_last_result, !busy, "busy after last word")
  `MWSM_ASSERT_NXT(a_close_sets_busy, start && !busy && in_last_pair, busy, "no busy after close")

endmodule

`default_nettype wire

>>> rtl/mwsm_opmem.sv
`default_nettype none

module mwsm_opmem #(
  parameter int OPERAND_WORDS = mwsm_pkg::OPERAND_WORDS,
  localparam int AW = (OPERAND_WORDS > 1) ? $clog2(OPERAND_WORDS) : 1
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [AW-1:0]               wr_addr,
  input  wire logic [mwsm_pkg::WORD_W-1:0] wr_a,
  input  wire logic [mwsm_pkg::WORD_W-1:0] wr_b,
  input  wire logic [AW-1:0]               rd_a_addr,
  input  wire logic [AW-1:0]               rd_b_addr,
  output logic      [mwsm_pkg::WORD_W-1:0] rd_a_q,
  output logic      [mwsm_pkg::WORD_W-1:0] rd_b_q
);

  logic [mwsm_pkg::WORD_W-1:0] a_mem [OPERAND_WORDS];
  logic [mwsm_pkg::WORD_W-1:0] b_mem [OPERAND_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      a_mem[wr_addr] <= wr_a;
      b_mem[wr_addr] <= wr_b;
    end
    rd_a_q <= a_mem[rd_a_addr];
    rd_b_q <= b_mem[rd_b_addr];
  end

endmodule

`default_nettype wire

>>> rtl/mwsm_prodmem.sv
`default_nettype none

module mwsm_prodmem #(
  parameter int OPERAND_WORDS = mwsm_pkg::OPERAND_WORDS,
  localparam int PW = $clog2(2 * OPERAND_WORDS)
) (
  input  wire logic                        clk,
  input  wire logic                        wr_en,
  input  wire logic [PW-1:0]               wr_addr,
  input  wire logic [mwsm_pkg::WORD_W-1:0] wr_data,
  input  wire logic [PW-1:0]               rd_addr,
  output logic      [mwsm_pkg::WORD_W-1:0] rd_q
);

  logic [mwsm_pkg::WORD_W-1:0] mem [2 * OPERAND_WORDS];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[rd_addr];
  end

endmodule

`default_nettype wire

>>> rtl/mwsm_mac.sv
`default_nettype none

module mwsm_mac #(
  parameter int OPERAND_WORDS = mwsm_pkg::OPERAND_WORDS,
  localparam int PW = $clog2(2 * OPERAND_WORDS)
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire mwsm_pkg::mac_ctl_t          ctl_in,
  input  wire logic [PW-1:0]               waddr_in,
  input  wire logic [mwsm_pkg::WORD_W-1:0] a_q,
  input  wire logic [mwsm_pkg::WORD_W-1:0] b_q,
  input  wire logic [mwsm_pkg::WORD_W-1:0] p_q,
  output logic                             wr_en,
  output logic      [PW-1:0]               wr_addr,
  output logic      [mwsm_pkg::WORD_W-1:0] wr_data
);

  localparam int W  = mwsm_pkg::WORD_W;
  localparam int DW = 2 * W;

  mwsm_pkg::mac_ctl_t ctl_s1_r, ctl_s2_r;
  logic [PW-1:0]      waddr_s1_r, waddr_s2_r;
  logic [DW-1:0]      prod_r;
  logic [W-1:0]       acc_r;
  logic [W-1:0]       carry_r;
  logic [W-1:0]       carry_in;
  logic [DW-1:0]      sum;

  // stage 1 waits for the memory reads, stage 2 holds the product
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_s1_r <= '0;
      ctl_s2_r <= '0;
    end else begin
      ctl_s1_r <= ctl_in;
      ctl_s2_r <= ctl_s1_r;
    end
  end

  always_ff @(posedge clk) begin
    waddr_s1_r <= waddr_in;
    waddr_s2_r <= waddr_s1_r;
    prod_r     <= ctl_s1_r.carry_step ? '0 : DW'(a_q) * DW'(b_q);
    acc_r      <= ctl_s1_r.zero_acc ? '0 : p_q;
    if (ctl_s2_r.valid) begin
      carry_r <= sum[DW-1:W];
    end
  end

  assign carry_in = ctl_s2_r.first ? '0 : carry_r;
  // never overflows: (2^32-1)^2 + 2*(2^32-1) = 2^64-1
  assign sum      = DW'(acc_r) + prod_r + DW'(carry_in);

  assign wr_en   = ctl_s2_r.valid;
  assign wr_addr = waddr_s2_r;
  assign wr_data = sum[W-1:0];

endmodule

`default_nettype wire

>>> rtl/mwsm_seq.sv
`default_nettype none

module mwsm_seq #(
  parameter int OPERAND_WORDS = mwsm_pkg::OPERAND_WORDS,
  localparam int AW = (OPERAND_WORDS > 1) ? $clog2(OPERAND_WORDS) : 1,
  localparam int CW = $clog2(OPERAND_WORDS + 1),
  localparam int PW = $clog2(2 * OPERAND_WORDS)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_start,
  input  wire logic          in_last_pair,
  output logic               busy,
  output logic               op_wr_en,
  output logic [AW-1:0]      op_wr_addr,
  output logic [AW-1:0]      a_rd_addr,
  output logic [AW-1:0]      b_rd_addr,
  output logic [PW-1:0]      p_rd_addr,
  output mwsm_pkg::mac_ctl_t issue,
  output logic [PW-1:0]      issue_waddr,
  output logic               out_strobe,
  output logic               out_last_result
);

  localparam logic [2:0] ST_LOAD  = 3'd0;
  localparam logic [2:0] ST_MUL   = 3'd1;
  localparam logic [2:0] ST_WAIT  = 3'd2;
  localparam logic [2:0] ST_DRAIN = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] n_r, n_nxt;
  logic [AW-1:0] i_r, i_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [PW-1:0] k_r, k_nxt;
  logic          wait_r, wait_nxt;
  logic          strobe_r, strobe_nxt;
  logic          last_r, last_nxt;
  logic          accept;
  logic          k_last;
  logic [PW-1:0] step_addr;

  assign accept    = in_start && (state_r == ST_LOAD);
  assign step_addr = PW'(i_r) + PW'(j_r);
  assign k_last    = ((CW + 1)'(k_r) == ({n_r, 1'b0} - (CW + 1)'(1)));

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    n_nxt      = n_r;
    i_nxt      = i_r;
    j_nxt      = j_r;
    k_nxt      = k_r;
    wait_nxt   = wait_r;
    strobe_nxt = 1'b0;
    last_nxt   = 1'b0;
    issue      = '0;
    case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (in_last_pair || (cnt_r == CW'(OPERAND_WORDS - 1))) begin
            n_nxt     = cnt_r + CW'(1);
            cnt_nxt   = '0;
            i_nxt     = '0;
            j_nxt     = '0;
            state_nxt = ST_MUL;
          end else begin
            cnt_nxt = cnt_r + CW'(1);
          end
        end
      end
      ST_MUL: begin
        issue.valid      = 1'b1;
        issue.first      = (j_r == '0);
        issue.carry_step = (j_r == n_r);
        issue.zero_acc   = (i_r == '0) || (j_r == n_r);
        if (j_r == n_r) begin
          j_nxt    = '0;
          wait_nxt = 1'b0;
          if ((CW'(i_r) + CW'(1)) == n_r) begin
            state_nxt = ST_DRAIN;
          end else begin
            i_nxt = i_r + AW'(1);
            // short rows would read a word before its write lands
            if (int'(n_r) < 3) begin
              state_nxt = ST_WAIT;
            end
          end
        end else begin
          j_nxt = j_r + CW'(1);
        end
      end
      ST_WAIT: begin
        if (wait_r) begin
          state_nxt = ST_MUL;
        end else begin
          wait_nxt = 1'b1;
        end
      end
      ST_DRAIN: begin
        if (wait_r) begin
          state_nxt = ST_EMIT;
          k_nxt     = '0;
        end else begin
          wait_nxt = 1'b1;
        end
      end
      ST_EMIT: begin
        strobe_nxt = 1'b1;
        last_nxt   = k_last;
        if (k_last) begin
          state_nxt = ST_LOAD;
        end else begin
          k_nxt = k_r + PW'(1);
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_LOAD;
      cnt_r    <= '0;
      n_r      <= '0;
      i_r      <= '0;
      j_r      <= '0;
      k_r      <= '0;
      wait_r   <= 1'b0;
      strobe_r <= 1'b0;
      last_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      n_r      <= n_nxt;
      i_r      <= i_nxt;
      j_r      <= j_nxt;
      k_r      <= k_nxt;
      wait_r   <= wait_nxt;
      strobe_r <= strobe_nxt;
      last_r   <= last_nxt;
    end
  end

  assign busy            = (state_r != ST_LOAD);
  assign op_wr_en        = accept;
  assign op_wr_addr      = cnt_r[AW-1:0];
  assign a_rd_addr       = i_r;
  assign b_rd_addr       = j_r[AW-1:0];
  assign p_rd_addr       = (state_r == ST_EMIT) ? k_r : step_addr;
  assign issue_waddr     = step_addr;
  assign out_strobe      = strobe_r;
  assign out_last_result = last_r;

endmodule

`default_nettype wire

>>> tb/multiword_schoolbook_multiplier_top_test.sv
`default_nettype none

typedef struct packed {
  logic [mwsm_pkg::WORD_W-1:0] word;
  logic                        last;
} product_word_t;

class product_scoreboard;
  localparam int MAX_WORDS = mwsm_pkg::OPERAND_WORDS;

  logic [mwsm_pkg::WORD_W-1:0] a_operand[$];
  logic [mwsm_pkg::WORD_W-1:0] b_operand[$];
  product_word_t               product_words[$];
  int                          mismatches;
  int                          pairs_taken;
  int                          products_formed;
  int                          full_products;
  int                          words_checked;

  function new();
    mismatches      = 0;
    pairs_taken     = 0;
    products_formed = 0;
    full_products   = 0;
    words_checked   = 0;
  endfunction

  // schoolbook product of the held operands, queued least significant first
  function void form_product();
    bit [mwsm_pkg::WORD_W-1:0] acc[2*MAX_WORDS];
    bit [63:0]                 t;
    bit [63:0]                 carry;
    product_word_t             pw;
    int                        n;
    n = a_operand.size();
    foreach (acc[k]) acc[k] = '0;
    for (int i = 0; i < n; i++) begin
      carry = '0;
      for (int j = 0; j < n; j++) begin
        t = 64'(acc[i+j]) + 64'(a_operand[i]) * 64'(b_operand[j]) + carry;
        acc[i+j] = t[31:0];
        carry = t >> 32;
      end
      acc[i+n] = carry[31:0];
    end
    for (int k = 0; k < 2*n; k++) begin
      pw.word = acc[k];
      pw.last = (k == 2*n - 1);
      product_words.push_back(pw);
    end
    products_formed++;
    if (n == MAX_WORDS) full_products++;
    a_operand.delete();
    b_operand.delete();
  endfunction

  function void note_pair(logic [mwsm_pkg::WORD_W-1:0] a, logic [mwsm_pkg::WORD_W-1:0] b,
                          logic last_pair);
    pairs_taken++;
    a_operand.push_back(a);
    b_operand.push_back(b);
    // a full store closes the operands whether or not the flag is set
    if (last_pair || a_operand.size() == MAX_WORDS) form_product();
  endfunction

  function void check_word(logic [mwsm_pkg::WORD_W-1:0] word, logic last);
    product_word_t want;
    words_checked++;
    if (product_words.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected product word %h last %b", word, last);
      return;
    end
    want = product_words.pop_front();
    if (word !== want.word || last !== want.last) begin
      mismatches++;
      if (mismatches <= 10)
        $display("product word mismatch: expected %h last %b, got %h last %b",
                 want.word, want.last, word, last);
    end
  endfunction

  function int pending();
    return product_words.size();
  endfunction
endclass

module multiword_schoolbook_multiplier_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_WORDS = mwsm_pkg::OPERAND_WORDS;

  logic                        clk          = 1'b0;
  logic                        rst_n        = 1'b0;
  logic                        start        = 1'b0;
  logic [mwsm_pkg::WORD_W-1:0] in_a_word    = '0;
  logic [mwsm_pkg::WORD_W-1:0] in_b_word    = '0;
  logic                        in_last_pair = 1'b0;
  logic                        busy;
  logic                        out_strobe;
  logic [mwsm_pkg::WORD_W-1:0] out_product_word;
  logic                        out_last_result;

  product_scoreboard sb = new();
  int                burst_left = 0;

  multiword_schoolbook_multiplier_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_a_word       (in_a_word),
    .in_b_word       (in_b_word),
    .in_last_pair    (in_last_pair),
    .out_strobe      (out_strobe),
    .out_product_word(out_product_word),
    .out_last_result (out_last_result)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) sb.check_word(out_product_word, out_last_result);
  end

  // extremes, single set or cleared bits and plain random words
  function automatic logic [mwsm_pkg::WORD_W-1:0] pick_word();
    logic [mwsm_pkg::WORD_W-1:0] w;
    case ($urandom_range(0, 7))
      0:       w = '0;
      1:       w = '1;
      2:       w = 32'd1 << $urandom_range(0, 31);
      3:       w = ~(32'd1 << $urandom_range(0, 31));
      default: w = $urandom();
    endcase
    return w;
  endfunction

  // sender idles between bursts of random length
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? 40 : $urandom_range(0, 11);
    end
  endtask

  task automatic send_pair(input logic [mwsm_pkg::WORD_W-1:0] a,
                           input logic [mwsm_pkg::WORD_W-1:0] b, input logic last_pair);
    start        <= 1'b1;
    in_a_word    <= a;
    in_b_word    <= b;
    in_last_pair <= last_pair;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_pair(a, b, last_pair);
    pace();
  endtask

  task automatic send_operands(input int n, input logic close_flag);
    for (int i = 0; i < n; i++)
      send_pair(pick_word(), pick_word(), (i == n - 1) ? close_flag : 1'b0);
  endtask

  initial begin
    int n;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_pair('0, '0, 1'b1);
    send_pair('1, '1, 1'b1);
    send_pair('1, '1, 1'b0);
    send_pair('1, '1, 1'b1);
    send_pair('0, '1, 1'b0);
    send_pair('1, '0, 1'b0);
    send_pair(32'h8000_0001, 32'h7fff_fffe, 1'b1);
    // sixteen pairs with no closing flag, the full store closes them
    for (int i = 0; i < MAX_WORDS; i++) send_pair('1, '1, 1'b0);

    while (sb.pairs_taken < 100) begin
      case ($urandom_range(0, 9))
        0:       n = MAX_WORDS;
        1, 2:    n = $urandom_range(5, MAX_WORDS - 1);
        default: n = $urandom_range(1, 4);
      endcase
      send_operands(n, (n == MAX_WORDS) ? 1'($urandom_range(0, 1)) : 1'b1);
    end
    start <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d operand pairs in %0d products, %0d of them at full length",
             sb.pairs_taken, sb.products_formed, sb.full_products);
    $display("%0d product words checked, %0d mismatches", sb.words_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("tb: failure");
    $finish;
  end
endmodule

`default_nettype wire

>>> files.f
+incdir+rtl
rtl/mwsm_pkg.sv
rtl/mwsm_opmem.sv
rtl/mwsm_prodmem.sv
rtl/mwsm_mac.sv
rtl/mwsm_seq.sv
rtl/multiword_schoolbook_multiplier_top.sv
tb/multiword_schoolbook_multiplier_top_test.sv
